FILE: rtl/sppe_pkg.sv
// Package with the sizes, field layouts and state encoding of the sweep-and-prune pair emitter.
`default_nettype none

package sppe_pkg;

    // Number of active queues, one for each body type.
    localparam int NUM_TYPES   = 4;
    // Entries in each circular active queue; a power of two.
    localparam int QUEUE_DEPTH = 16;
    // Number of bodies that can be addressed.
    localparam int MAX_BODIES  = 1024;

    localparam int END_W   = 24;
    localparam int INDEX_W = $clog2(MAX_BODIES);
    localparam int TYPE_W  = 2;
    localparam int QD_W    = $clog2(QUEUE_DEPTH);
    localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
    localparam int SLOT_W  = TYPE_W + QD_W;
    localparam int SLOTS   = NUM_TYPES * QUEUE_DEPTH;
    localparam int ENTRY_W = END_W + INDEX_W;

    // Input request: tdata = {pad, body_index, right_end, left_end},
    // tuser = {body_type, frame_start}.
    localparam int S_FIELDS_W = 2 * END_W + INDEX_W;
    localparam int S_DATA_W   = ((S_FIELDS_W + 7) / 8) * 8;
    localparam int S_USER_W   = 1 + TYPE_W;

    // Output request: tdata = {pad, active_index, new_index},
    // tuser = {overflow, pair_valid}.
    localparam int M_FIELDS_W = 2 * INDEX_W;
    localparam int M_DATA_W   = ((M_FIELDS_W + 7) / 8) * 8;
    localparam int M_USER_W   = 2;

    typedef enum logic [5:0] {
        S_IDLE    = 6'b000001,
        S_POP_RD  = 6'b000010,
        S_POP_CHK = 6'b000100,
        S_EM_RD   = 6'b001000,
        S_EM_WAIT = 6'b010000,
        S_FIN     = 6'b100000
    } t_state;

endpackage

`default_nettype wire

FILE: rtl/sweep_prune_pair_emitter_unit.sv
// Sweep-and-prune broad phase: per-type active queues in one memory, emits candidate pairs.
// Each item sweeps the queues in type order: it pops the entries whose right end lies below
// its left end, then reads every remaining entry to emit a pair; the single read port of the
// active-entry memory does one read, then a state uses its registered data.
// Throughput: one item at a time; the next request is taken once the last result is registered.
// Reset: synchronous, active low; it empties all queues. The entry memory itself is not cleared.
`default_nettype none

module sweep_prune_pair_emitter_unit
    import sppe_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_s_axis_tvalid,
    output logic                     o_s_axis_tready,
    // Fields from bit 0 up: left_end[23:0], right_end[47:24], body_index[57:48], zero pad.
    input  wire logic [S_DATA_W-1:0] i_s_axis_tdata,
    // Fields from bit 0 up: frame_start[0], body_type[2:1].
    input  wire logic [S_USER_W-1:0] i_s_axis_tuser,
    output logic                     o_m_axis_tvalid,
    input  wire logic                i_m_axis_tready,
    // Fields from bit 0 up: new_index[9:0], active_index[19:10], zero pad.
    output logic [M_DATA_W-1:0]      o_m_axis_tdata,
    // Fields from bit 0 up: pair_valid[0], overflow[1].
    output logic [M_USER_W-1:0]      o_m_axis_tuser,
    output logic                     o_m_axis_tlast
);

    // The active-entry memory holds {right end, body index}. Queue t owns the slots whose
    // upper address bits equal t; head and count registers make each one a circular FIFO.
    logic [ENTRY_W-1:0] r_store [0:SLOTS-1];
    logic [ENTRY_W-1:0] r_rd_data;

    logic [QD_W-1:0]  r_head [0:NUM_TYPES-1];
    logic [CNT_W-1:0] r_cnt  [0:NUM_TYPES-1];

    t_state r_state;
    logic [TYPE_W-1:0] r_t;     // queue being swept
    logic [CNT_W-1:0]  r_i;     // offset of the entry being emitted

    // Fields of the item in flight.
    logic signed [END_W-1:0] r_left;
    logic [END_W-1:0]        r_right;
    logic [INDEX_W-1:0]      r_index;
    logic [TYPE_W-1:0]       r_type;
    logic                    r_ovf;

    // One pair is held back until it is known whether another one follows, so that the
    // final result of the item can carry last.
    logic               r_pend_v;
    logic [INDEX_W-1:0] r_pend_idx;

    // Output register.
    logic               r_out_v;
    logic               r_out_pv;
    logic               r_out_ovf;
    logic               r_out_last;
    logic [INDEX_W-1:0] r_out_new;
    logic [INDEX_W-1:0] r_out_act;

    logic                    w_accept;
    logic                    w_fs;
    logic [TYPE_W-1:0]       w_in_type;
    logic [TYPE_W-1:0]       w_qsel;
    logic [QD_W-1:0]         w_head;
    logic [CNT_W-1:0]        w_cnt;
    logic                    w_ovf_in;
    logic                    w_out_free;
    logic                    w_last_type;
    logic                    w_pop;
    logic signed [END_W-1:0] w_rd_right;
    logic                    w_re;
    logic [SLOT_W-1:0]       w_raddr;
    logic                    w_we;
    logic [SLOT_W-1:0]       w_waddr;
    logic [ENTRY_W-1:0]      w_wdata;

    assign w_accept  = i_s_axis_tvalid && o_s_axis_tready;
    assign w_fs      = i_s_axis_tuser[0];
    assign w_in_type = i_s_axis_tuser[TYPE_W:1];

    // The head and count registers are looked up at one place: the incoming type while
    // idle, the item's own type at the final push, and the swept queue otherwise.
    always_comb begin
        priority if (r_state == S_IDLE) begin
            w_qsel = w_in_type;
        end else if (r_state == S_FIN) begin
            w_qsel = r_type;
        end else begin
            w_qsel = r_t;
        end
    end

    assign w_head = r_head[w_qsel];
    assign w_cnt  = r_cnt[w_qsel];

    // A frame start empties the queues first, so only a type without a queue overflows then.
    assign w_ovf_in = (int'(w_in_type) >= NUM_TYPES) ||
                      (!w_fs && (w_cnt >= CNT_W'(QUEUE_DEPTH)));

    assign w_out_free  = !r_out_v || i_m_axis_tready;
    assign w_last_type = (r_t == TYPE_W'(NUM_TYPES - 1));

    // An entry whose right end equals the new left end stays active.
    assign w_rd_right = r_rd_data[ENTRY_W-1 -: END_W];
    assign w_pop      = r_left > w_rd_right;

    // Memory ports: reads while sweeping, the single write at the end of the item.
    assign w_re = ((r_state == S_POP_RD) && (w_cnt != '0)) ||
                  ((r_state == S_EM_RD) && (r_i != w_cnt));
    assign w_raddr = {r_t, w_head + ((r_state == S_EM_RD) ? r_i[QD_W-1:0] : QD_W'(0))};
    assign w_we    = (r_state == S_FIN) && w_out_free && !r_ovf;
    assign w_waddr = {r_type, w_head + w_cnt[QD_W-1:0]};
    assign w_wdata = {r_right, r_index};

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_store[w_waddr] <= w_wdata;
        end
        if (w_re) begin
            r_rd_data <= r_store[w_raddr];
        end
    end

    // Control: sequencer, queue pointers, held-pair flag and output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_t      <= '0;
            r_i      <= '0;
            r_pend_v <= 1'b0;
            r_out_v  <= 1'b0;
            for (int k = 0; k < NUM_TYPES; k++) begin
                r_head[k] <= '0;
                r_cnt[k]  <= '0;
            end
        end else begin
            if (i_m_axis_tready) begin
                r_out_v <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        if (w_fs) begin
                            for (int k = 0; k < NUM_TYPES; k++) begin
                                r_head[k] <= '0;
                                r_cnt[k]  <= '0;
                            end
                        end
                        r_t      <= '0;
                        r_pend_v <= 1'b0;
                        r_state  <= S_POP_RD;
                    end
                end
                S_POP_RD: begin
                    // Empty queue: move on; otherwise its front entry is being read.
                    if (w_cnt == '0) begin
                        if (w_last_type) begin
                            r_state <= S_FIN;
                        end else begin
                            r_t <= r_t + 1'b1;
                        end
                    end else begin
                        r_state <= S_POP_CHK;
                    end
                end
                S_POP_CHK: begin
                    if (w_pop) begin
                        r_head[r_t] <= w_head + 1'b1;
                        r_cnt[r_t]  <= w_cnt - 1'b1;
                        r_state     <= S_POP_RD;
                    end else begin
                        r_i     <= '0;
                        r_state <= S_EM_RD;
                    end
                end
                S_EM_RD: begin
                    if (r_i == w_cnt) begin
                        if (w_last_type) begin
                            r_state <= S_FIN;
                        end else begin
                            r_t     <= r_t + 1'b1;
                            r_state <= S_POP_RD;
                        end
                    end else begin
                        r_state <= S_EM_WAIT;
                    end
                end
                S_EM_WAIT: begin
                    // The held pair goes out and the one just read takes its place.
                    if (!r_pend_v || w_out_free) begin
                        if (r_pend_v) begin
                            r_out_v <= 1'b1;
                        end
                        r_pend_v <= 1'b1;
                        r_i      <= r_i + 1'b1;
                        r_state  <= S_EM_RD;
                    end
                end
                S_FIN: begin
                    if (w_out_free) begin
                        r_out_v <= 1'b1;
                        if (!r_ovf) begin
                            r_cnt[r_type] <= w_cnt + 1'b1;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Payload: item fields, held pair and output fields.
    always_ff @(posedge i_clk) begin
        if ((r_state == S_IDLE) && w_accept) begin
            r_left  <= i_s_axis_tdata[END_W-1:0];
            r_right <= i_s_axis_tdata[2*END_W-1:END_W];
            r_index <= i_s_axis_tdata[2*END_W +: INDEX_W];
            r_type  <= w_in_type;
            r_ovf   <= w_ovf_in;
        end
        if ((r_state == S_EM_WAIT) && (!r_pend_v || w_out_free)) begin
            r_pend_idx <= r_rd_data[INDEX_W-1:0];
            if (r_pend_v) begin
                r_out_pv   <= 1'b1;
                r_out_act  <= r_pend_idx;
                r_out_new  <= r_index;
                r_out_ovf  <= r_ovf;
                r_out_last <= 1'b0;
            end
        end
        if ((r_state == S_FIN) && w_out_free) begin
            // With no pair at all the item still gets one empty result.
            r_out_pv   <= r_pend_v;
            r_out_act  <= r_pend_v ? r_pend_idx : INDEX_W'(0);
            r_out_new  <= r_index;
            r_out_ovf  <= r_ovf;
            r_out_last <= 1'b1;
        end
    end

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_out_v;
    assign o_m_axis_tdata  = {{(M_DATA_W - M_FIELDS_W){1'b0}}, r_out_act, r_out_new};
    assign o_m_axis_tuser  = {r_out_ovf, r_out_pv};
    assign o_m_axis_tlast  = r_out_last;

endmodule

`default_nettype wire
